>>> src/lct_pkg.sv
// lct_pkg: shared types and codes for the level crossing trigger
// holds register indexes, mode codes, config and classified item structs
// no dependencies
`default_nettype none

package lct_pkg;

   // widths of the stream fields
   localparam int SampleW = 32;
   localparam int TimeW   = 32;
   localparam int HoldW   = 31;
   localparam int BandW   = 31;
   localparam int ModeW   = 2;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam int ReqDataW = SampleW + TimeW;
   localparam int RspDataW = 8;
   // wide enough for 2*(sample - reference) +/- band without overflow
   localparam int CmpW = SampleW + 3;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;
   localparam int QueueCntW  = 2;

   // register indexes
   localparam logic [CsrAddrW-1:0] REG_FIRE_ON_RISE  = 3'd0;
   localparam logic [CsrAddrW-1:0] REG_FIRE_ON_FALL  = 3'd1;
   localparam logic [CsrAddrW-1:0] REG_FIRE_ON_MATCH = 3'd2;
   localparam logic [CsrAddrW-1:0] REG_TRIGGER_MODE  = 3'd3;
   localparam logic [CsrAddrW-1:0] REG_HOLD_MS       = 3'd4;
   localparam logic [CsrAddrW-1:0] REG_REFERENCE     = 3'd5;
   localparam logic [CsrAddrW-1:0] REG_BAND_WIDTH    = 3'd6;

   // trigger modes
   localparam logic [ModeW-1:0] MODE_ONE_TIME = 2'd0;
   localparam logic [ModeW-1:0] MODE_REARM    = 2'd1;
   localparam logic [ModeW-1:0] MODE_TOGGLE   = 2'd2;

   typedef struct packed {
      logic                      fire_on_rise;
      logic                      fire_on_fall;
      logic                      fire_on_match;
      logic [ModeW-1:0]          trigger_mode;
      logic [HoldW-1:0]          hold_ms;
      logic signed [SampleW-1:0] reference_level;
      logic [BandW-1:0]          band_width;
   } cfg_type;

   // one item after classification against the band
   typedef struct packed {
      logic             below;    // d <= -band
      logic             above;    // d >= band
      logic             nonneg;   // d >= 0
      logic             nonpos;   // d <= 0
      logic             near;     // 2|d| <= band
      logic [TimeW-1:0] now_ms;
   } class_type;

endpackage

`default_nettype wire

>>> src/lct_front.sv
// lct_front: accepts sample items and classifies them against the band
// one register stage; uses lct_pkg
`default_nettype none

module lct_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire lct_pkg::cfg_type        cfg,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [lct_pkg::ReqDataW-1:0]  req_tdata,
   output logic                         push_valid,
   input  wire                          push_ready,
   output lct_pkg::class_type           push_item
);
   import lct_pkg::*;

   logic                    valid_ff, valid_in;
   class_type               item_ff, item_in;
   logic signed [CmpW-1:0]  s_x, r_x, b_x;
   logic signed [CmpW-1:0]  low_sum, high_sum, near_lo, near_hi;
   logic                    take;

   // sign-extend operands to the compare width
   always_comb begin
      s_x = CmpW'($signed(req_tdata[SampleW-1:0]));
      r_x = CmpW'(cfg.reference_level);
      b_x = $signed({{(CmpW-BandW){1'b0}}, cfg.band_width});
   end

   // parallel three-input sums, each checked by sign or zero
   always_comb begin
      low_sum  = s_x - r_x + b_x;
      high_sum = s_x - r_x - b_x;
      near_lo  = (s_x <<< 1) - (r_x <<< 1) - b_x;
      near_hi  = (s_x <<< 1) - (r_x <<< 1) + b_x;
      item_in.below  = (low_sum <= 0);
      item_in.above  = (high_sum >= 0);
      item_in.nonneg = (s_x >= r_x);
      item_in.nonpos = (s_x <= r_x);
      item_in.near   = (near_lo <= 0) && (near_hi >= 0);
      item_in.now_ms = req_tdata[ReqDataW-1:SampleW];
   end

   // stage handshake
   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

`default_nettype wire

>>> src/lct_queue.sv
// lct_queue: short queue of classified items between front and back
// two entries with registered storage; uses lct_pkg
`default_nettype none

module lct_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push_valid,
   output logic                  push_ready,
   input  wire lct_pkg::class_type push_item,
   output logic                  pop_valid,
   input  wire                   pop_ready,
   output lct_pkg::class_type    pop_item,
   output logic [lct_pkg::QueueCntW-1:0] count
);
   import lct_pkg::*;

   class_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != QueueCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> src/lct_back.sv
// lct_back: arming state, firing decision and output level per item
// holds the result register; uses lct_pkg
`default_nettype none

module lct_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire lct_pkg::cfg_type        cfg,
   input  wire                          pop_valid,
   output logic                         pop_ready,
   input  wire lct_pkg::class_type      pop_item,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [lct_pkg::RspDataW-1:0] rsp_tdata
);
   import lct_pkg::*;

   logic             rise_ff, rise_in;
   logic             fall_ff, fall_in;
   logic             match_ff, match_in;
   logic [TimeW-1:0] last_ff, last_in;
   logic             level_ff, level_in;
   logic             out_valid_ff, out_valid_in;
   logic             active_ff, fired_ff;
   logic             rise_a, fall_a, match_a;
   logic             fire_r, fire_f, fire_m;
   logic             cont, trig, in_hold;
   logic             pop;

   assign pop_ready = !out_valid_ff || rsp_tready;
   assign pop       = pop_valid && pop_ready;
   assign cont      = (cfg.trigger_mode == MODE_REARM);

   // arm, then fire on the crossing
   always_comb begin
      rise_a  = rise_ff  || pop_item.below;
      fall_a  = fall_ff  || pop_item.above;
      match_a = match_ff || pop_item.below || pop_item.above;
      fire_r  = rise_a  && pop_item.nonneg;
      fire_f  = fall_a  && pop_item.nonpos;
      fire_m  = match_a && pop_item.near;
      rise_in  = fire_r ? cont : rise_a;
      fall_in  = fall_a && !fire_f || fire_f && cont;
      match_in = fire_m ? cont : match_a;
      trig = (fire_r && cfg.fire_on_rise) || (fire_f && cfg.fire_on_fall) ||
             (fire_m && cfg.fire_on_match);
   end

   // output level by mode; a fresh trigger gives zero elapsed time
   assign in_hold = ((pop_item.now_ms - last_ff) <= TimeW'(cfg.hold_ms));

   always_comb begin
      last_in  = last_ff;
      level_in = level_ff;
      unique case (cfg.trigger_mode)
         MODE_ONE_TIME, MODE_REARM: begin
            last_in  = trig ? pop_item.now_ms : last_ff;
            level_in = trig || in_hold;
         end
         MODE_TOGGLE: begin
            level_in = level_ff ^ trig;
         end
         default: begin
            level_in = level_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff  <= 1'b0;
         fall_ff  <= 1'b0;
         match_ff <= 1'b0;
         last_ff  <= '0;
         level_ff <= 1'b0;
      end else if (pop) begin
         rise_ff  <= rise_in;
         fall_ff  <= fall_in;
         match_ff <= match_in;
         last_ff  <= last_in;
         level_ff <= level_in;
      end
   end

   // result register
   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         active_ff <= level_in;
         fired_ff  <= trig;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataW-2){1'b0}}, fired_ff, active_ff};

endmodule

`default_nettype wire

>>> src/level_cross_trigger.sv
// level_cross_trigger: top level of the level crossing trigger
// holds the config registers; uses lct_pkg, lct_front, lct_queue, lct_back
//
//   channel  dir  tdata fields (low bit up)          handshake
//   req_     in   sample[31:0], now_ms[63:32]        tvalid/tready
//   rsp_     out  active[0], fired[1], zero pad      tvalid/tready
//   csr_     in   we, addr (register index), wdata   write on we
//
// one item per cycle sustained while rsp_tready holds; each item passes from accept
// to result through the classify register, the queue entry and the result register.
// the arming flags and output level close a loop through their own registers in the back end.
// reset is synchronous and clears arming state, timestamps and all valids.
// either side may stall alone; the two-entry queue absorbs the difference.
`default_nettype none

module level_cross_trigger (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [lct_pkg::ReqDataW-1:0]  req_tdata,   // sample, now_ms
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [lct_pkg::RspDataW-1:0] rsp_tdata,   // active, fired, pad
   input  wire                          csr_we,
   input  wire [lct_pkg::CsrAddrW-1:0]  csr_addr,
   input  wire [lct_pkg::CsrDataW-1:0]  csr_wdata
);
   import lct_pkg::*;

   cfg_type               cfg_ff;
   logic                  q_push_valid, q_push_ready;
   class_type             q_push_item;
   logic                  q_pop_valid, q_pop_ready;
   class_type             q_pop_item;
   logic [QueueCntW-1:0]  q_count;

   // config register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_FIRE_ON_RISE:  cfg_ff.fire_on_rise    <= csr_wdata[0];
            REG_FIRE_ON_FALL:  cfg_ff.fire_on_fall    <= csr_wdata[0];
            REG_FIRE_ON_MATCH: cfg_ff.fire_on_match   <= csr_wdata[0];
            REG_TRIGGER_MODE:  cfg_ff.trigger_mode    <= csr_wdata[ModeW-1:0];
            REG_HOLD_MS:       cfg_ff.hold_ms         <= csr_wdata[HoldW-1:0];
            REG_REFERENCE:     cfg_ff.reference_level <= $signed(csr_wdata[SampleW-1:0]);
            REG_BAND_WIDTH:    cfg_ff.band_width      <= csr_wdata[BandW-1:0];
            default: begin
            end
         endcase
      end
   end

   lct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item)
   );

   lct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item),
      .count      (q_count)
   );

   lct_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QueueCntW'(QueueDepth))
      else $error("queue count above depth");

   // a reported trigger needs an enabled crossing kind
   a_fire_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |->
         (cfg_ff.fire_on_rise || cfg_ff.fire_on_fall || cfg_ff.fire_on_match))
      else $error("trigger reported with no crossing kind enabled");

   // in the timed modes a trigger always leaves the output active
   a_timed_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] &&
      (cfg_ff.trigger_mode == MODE_ONE_TIME || cfg_ff.trigger_mode == MODE_REARM)
      |-> rsp_tdata[0])
      else $error("timed mode trigger without active output");

   // an item in the queue is drained when the result side is free
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      q_count != '0 && !rsp_tvalid |=> q_count != QueueCntW'(QueueDepth) || rsp_tvalid)
      else $error("queue stalled with free result register");

endmodule

`default_nettype wire
